[hdl/smco_pkg.sv]
// Shared types, constants and helpers for the screen melt column offset block.
// Used by smco_rng and screen_melt_column_offsets; depends on nothing else.
package smco_pkg;

   // Storage limits
   localparam int MAX_COLUMNS = 160;
   localparam int MAX_HEIGHT  = 480;

   // Widths
   localparam int COL_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CNT_W      = $clog2(MAX_COLUMNS + 1);
   localparam int OFF_W      = 10;
   localparam int HGT_W      = 9;
   localparam int COUNT_W    = 8;
   localparam int IDX_W      = 8;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;
   localparam int SEED_W     = 32;

   // Linear congruential generator
   localparam logic [SEED_W-1:0] LCG_MUL    = 32'd1103515245;
   localparam logic [SEED_W-1:0] LCG_INC    = 32'd12345;
   localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;

   // Register reset values
   localparam logic [HGT_W-1:0]   HEIGHT_RESET = 9'd240;
   localparam logic [COUNT_W-1:0] COUNT_RESET  = 8'd80;

   // Column motion constants
   localparam logic signed [OFF_W-1:0] OFF_ZERO    = 10'sd0;
   localparam logic signed [OFF_W-1:0] OFF_ONE     = 10'sd1;
   localparam logic signed [OFF_W-1:0] OFF_MIN     = -10'sd15;
   localparam logic signed [OFF_W-1:0] ACCEL_LIMIT = 10'sd16;
   localparam logic signed [OFF_W-1:0] ACCEL_STEP  = 10'sd8;

   typedef enum logic [MODE_W-1:0] {
      MODE_START = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_QUERY = 2'd2,
      MODE_STOP  = 2'd3
   } smco_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEIGHT = 1'b0,
      CSR_COUNT  = 1'b1
   } smco_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_TICK,
      ST_QUERY,
      ST_FIN
   } smco_state_type;

   // Random draws handed from the generator to the sequencer
   typedef struct packed {
      logic [3:0] mod16;
      logic [1:0] mod3;
   } smco_rand_type;

   // Remainder by three of a 15-bit value: base-4 digits all weigh one mod 3
   function automatic logic [1:0] mod3_15(input logic [14:0] value);
      logic [15:0] wide;
      logic [4:0]  sum;
      logic [2:0]  fold;
      logic [1:0]  res;
      wide = {1'b0, value};
      sum  = '0;
      for (int i = 0; i < 8; i++) begin
         sum = sum + 5'(wide[2*i +: 2]);
      end
      fold = 3'(sum[4]) + 3'(sum[3:2]) + 3'(sum[1:0]);
      case (fold) inside
         3'd0, 3'd3, 3'd6: res = 2'd0;
         3'd1, 3'd4, 3'd7: res = 2'd1;
         default:          res = 2'd2;
      endcase
      return res;
   endfunction

endpackage

[hdl/smco_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module smco_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/smco_rng.sv]
// Persistent 32-bit linear congruential seed and the draws taken from it.
// Depends on smco_pkg for the constants and the mod-3 helper.
module smco_rng (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   output smco_pkg::smco_rand_type rand_out
);
   import smco_pkg::*;

   logic [SEED_W-1:0]   seed_ff;
   logic [SEED_W-1:0]   seed_in;
   logic [2*SEED_W-1:0] product;

   // Advance the seed by one generator step when asked
   always_comb begin
      product = seed_ff * LCG_MUL;
      seed_in = seed_ff;
      if (step) begin
         seed_in = product[SEED_W-1:0] + LCG_INC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // Random value is bits 30:16 of the current seed
   always_comb begin
      rand_out.mod16 = seed_ff[19:16];
      rand_out.mod3  = mod3_15(seed_ff[30:16]);
   end

endmodule

[hdl/screen_melt_column_offsets.sv]
// Screen melt column offsets: start and tick walk the columns (one RAM entry written per
// cycle by the column sequencer), query reads one entry, stop and ignored items go straight
// to the result; one transaction in flight, result held in an output register.
// Reset (synchronous): all offsets read as zero through per-entry valid bits, seed 1,
// melt inactive, height 240, column count 80.
// Depends on smco_pkg, smco_ram and smco_rng.
module screen_melt_column_offsets (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [smco_pkg::MODE_W-1:0]         req_mode,
   input  logic [smco_pkg::IDX_W-1:0]          req_column_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_active,
   output logic signed [smco_pkg::OFF_W-1:0]   rsp_column_offset,
   output logic [smco_pkg::HGT_W-1:0]          rsp_strip_top,
   output logic [smco_pkg::HGT_W-1:0]          rsp_strip_rows,
   output logic                                rsp_strip_visible,
   input  logic                                csr_wr_en,
   input  logic [smco_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [smco_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import smco_pkg::*;

   smco_state_type state_ff, state_in;

   logic                     active_ff, active_in;
   logic [HGT_W-1:0]         height_ff, height_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     valid_ff [MAX_COLUMNS];
   logic                     rd_hit_ff;
   logic [COL_W-1:0]         rd_cnt_ff, rd_cnt_in;
   logic [COL_W-1:0]         wr_cnt_ff, wr_cnt_in;
   logic signed [OFF_W-1:0]  prev_ff, prev_in;
   logic                     moving_ff, moving_in;
   logic                     in_range_ff, in_range_in;
   logic signed [OFF_W-1:0]  p_off_ff, p_off_in;
   logic [HGT_W-1:0]         p_top_ff, p_top_in;
   logic [HGT_W-1:0]         p_rows_ff, p_rows_in;
   logic                     p_vis_ff, p_vis_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_active_ff;
   logic signed [OFF_W-1:0]  rsp_off_ff;
   logic [HGT_W-1:0]         rsp_top_ff, rsp_rows_ff;
   logic                     rsp_vis_ff;

   logic                     req_fire, rsp_load, last_col;
   smco_mode_type            mode;
   logic [CNT_W-1:0]         n_eff;
   logic [COL_W-1:0]         n_last;
   logic [HGT_W-1:0]         h_eff;
   logic signed [OFF_W-1:0]  h_signed;

   logic                     ram_wr_en;
   logic [COL_W-1:0]         ram_wr_addr, ram_rd_addr;
   logic [OFF_W-1:0]         ram_wr_data, ram_rd_data;
   logic                     rng_step;
   smco_rand_type            rnd;

   logic signed [OFF_W-1:0]  rd_off;
   logic signed [OFF_W-1:0]  seed_first, seed_step, seed_val;
   logic signed [OFF_W-1:0]  tick_inc, tick_sum, tick_val;
   logic                     tick_moves;
   logic signed [OFF_W-1:0]  q_off;
   logic [HGT_W-1:0]         q_top;
   logic signed [OFF_W:0]    q_rows_wide;

   // Column offset store and seed generator
   smco_ram #(
      .WIDTH (OFF_W),
      .DEPTH (MAX_COLUMNS)
   ) u_offsets (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   smco_rng u_rng (
      .clock    (clock),
      .reset    (reset),
      .step     (rng_step),
      .rand_out (rnd)
   );

   // Effective geometry from the configuration registers
   always_comb begin
      if (count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (9'(count_ff) > 9'(MAX_COLUMNS)) begin
         n_eff = CNT_W'(MAX_COLUMNS);
      end else begin
         n_eff = CNT_W'(count_ff);
      end
      n_last = COL_W'(n_eff - CNT_W'(1));
      if (11'(height_ff) > 11'(MAX_HEIGHT)) begin
         h_eff = HGT_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      h_signed = $signed({1'b0, h_eff});
   end

   assign req_fire = req_valid && !req_stall;
   assign mode     = smco_mode_type'(req_mode);
   assign rsp_load = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign last_col = (wr_cnt_ff == n_last);

   // Read data: an entry never written reads as zero
   assign rd_off = rd_hit_ff ? $signed(ram_rd_data) : OFF_ZERO;

   // Seeding walk: first column from the draw mod 16, later ones step by -1..+1
   always_comb begin
      seed_first = -$signed({{(OFF_W-4){1'b0}}, rnd.mod16});
      seed_step  = prev_ff + $signed({{(OFF_W-2){1'b0}}, rnd.mod3}) - OFF_ONE;
      if (seed_step > OFF_ZERO) begin
         seed_step = OFF_ZERO;
      end else if (seed_step < OFF_MIN) begin
         seed_step = OFF_MIN;
      end
      seed_val = (wr_cnt_ff == '0) ? seed_first : seed_step;
   end

   // Tick: count up a delay, otherwise accelerate and clamp at the height
   always_comb begin
      tick_inc   = (rd_off < ACCEL_LIMIT) ? (rd_off + OFF_ONE) : ACCEL_STEP;
      tick_sum   = rd_off + tick_inc;
      tick_val   = rd_off;
      tick_moves = 1'b0;
      if (rd_off < OFF_ZERO) begin
         tick_val   = rd_off + OFF_ONE;
         tick_moves = 1'b1;
      end else if (rd_off < h_signed) begin
         tick_val   = (tick_sum > h_signed) ? h_signed : tick_sum;
         tick_moves = 1'b1;
      end
   end

   // Query geometry
   always_comb begin
      q_off       = in_range_ff ? rd_off : OFF_ZERO;
      q_top       = (q_off > OFF_ZERO) ? q_off[HGT_W-1:0] : '0;
      q_rows_wide = $signed({2'b00, h_eff}) - $signed({2'b00, q_top});
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (mode)
                  MODE_START: state_in = active_ff ? ST_FIN : ST_SEED;
                  MODE_TICK:  state_in = active_ff ? ST_TICK : ST_FIN;
                  MODE_QUERY: state_in = ST_QUERY;
                  MODE_STOP:  state_in = ST_FIN;
               endcase
            end
         end
         ST_SEED:  state_in = last_col ? ST_FIN : ST_SEED;
         ST_TICK:  state_in = last_col ? ST_FIN : ST_TICK;
         ST_QUERY: state_in = ST_FIN;
         ST_FIN:   state_in = rsp_load ? ST_IDLE : ST_FIN;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake, RAM ports and generator step
   always_comb begin
      req_stall   = 1'b1;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_cnt_ff;
      ram_wr_data = seed_val;
      ram_rd_addr = rd_cnt_ff;
      rng_step    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            ram_rd_addr = (mode == MODE_QUERY) ? COL_W'(req_column_index) : '0;
            rng_step    = req_fire && (mode == MODE_START) && !active_ff;
         end
         ST_SEED: begin
            ram_wr_en = 1'b1;
            rng_step  = !last_col;
         end
         ST_TICK: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = tick_val;
         end
         ST_QUERY: begin
         end
         ST_FIN: begin
         end
         default: begin
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      active_in   = active_ff;
      height_in   = height_ff;
      count_in    = count_ff;
      rd_cnt_in   = rd_cnt_ff;
      wr_cnt_in   = wr_cnt_ff;
      prev_in     = prev_ff;
      moving_in   = moving_ff;
      in_range_in = in_range_ff;
      p_off_in    = p_off_ff;
      p_top_in    = p_top_ff;
      p_rows_in   = p_rows_ff;
      p_vis_in    = p_vis_ff;

      // Configuration writes
      if (csr_wr_en) begin
         unique case (smco_csr_type'(csr_index))
            CSR_HEIGHT: height_in = csr_wdata;
            CSR_COUNT:  count_in  = csr_wdata[COUNT_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               p_off_in  = OFF_ZERO;
               p_top_in  = '0;
               p_rows_in = '0;
               p_vis_in  = 1'b0;
               rd_cnt_in = COL_W'(1);
               wr_cnt_in = '0;
               moving_in = 1'b0;
               in_range_in = (9'(req_column_index) < 9'(n_eff));
               if (mode == MODE_STOP) begin
                  active_in = 1'b0;
               end
            end
         end
         ST_SEED: begin
            prev_in = seed_val;
            if (last_col) begin
               active_in = 1'b1;
            end else begin
               wr_cnt_in = wr_cnt_ff + COL_W'(1);
            end
         end
         ST_TICK: begin
            rd_cnt_in = rd_cnt_ff + COL_W'(1);
            moving_in = moving_ff || tick_moves;
            if (last_col) begin
               active_in = moving_ff || tick_moves;
            end else begin
               wr_cnt_in = wr_cnt_ff + COL_W'(1);
            end
         end
         ST_QUERY: begin
            if (in_range_ff) begin
               p_off_in  = q_off;
               p_top_in  = q_top;
               p_rows_in = (q_rows_wide < 0) ? '0 : q_rows_wide[HGT_W-1:0];
               p_vis_in  = active_ff && (q_off < h_signed) && (q_rows_wide > 1);
            end
         end
         ST_FIN: begin
         end
         default: begin
         end
      endcase
   end

   // Output register: hold while stalled, load when the result is done
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         height_ff    <= HEIGHT_RESET;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_COLUMNS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         height_ff    <= height_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_wr_en) begin
            valid_ff[ram_wr_addr] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_hit_ff   <= valid_ff[ram_rd_addr];
      rd_cnt_ff   <= rd_cnt_in;
      wr_cnt_ff   <= wr_cnt_in;
      prev_ff     <= prev_in;
      moving_ff   <= moving_in;
      in_range_ff <= in_range_in;
      p_off_ff    <= p_off_in;
      p_top_ff    <= p_top_in;
      p_rows_ff   <= p_rows_in;
      p_vis_ff    <= p_vis_in;
      if (rsp_load) begin
         rsp_active_ff <= active_ff;
         rsp_off_ff    <= p_off_ff;
         rsp_top_ff    <= p_top_ff;
         rsp_rows_ff   <= p_rows_ff;
         rsp_vis_ff    <= p_vis_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_active        = rsp_active_ff;
   assign rsp_column_offset = rsp_off_ff;
   assign rsp_strip_top     = rsp_top_ff;
   assign rsp_strip_rows    = rsp_rows_ff;
   assign rsp_strip_visible = rsp_vis_ff;

   // A visible strip belongs to a running melt and has more than one row
   a_vis_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_strip_visible |-> rsp_active && (rsp_strip_rows > 9'd1))
      else $error("visible strip without active melt or enough rows");

   // The offset store is written only by the seeding and tick walks
   a_wr_walk: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_SEED) || (state_ff == ST_TICK))
      else $error("offset store written outside a column walk");

   // The tick walk reads one column ahead of the column it writes back
   a_tick_ahead: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TICK |-> rd_cnt_ff == wr_cnt_ff + COL_W'(1))
      else $error("tick read and write-back out of step");

   // Finishing the seeding walk leaves the melt running
   a_seed_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEED) && last_col |=> active_ff)
      else $error("melt not active after seeding");

endmodule

[dv/screen_melt_column_offsets_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for screen_melt_column_offsets: start, tick, query and stop
// transactions under random idling, each response checked against a local predictor.
// Depends on smco_pkg and the screen_melt_column_offsets RTL.
module screen_melt_column_offsets_tb;
   import smco_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 400;
   localparam int PHASE_ITEMS  = 65;

   typedef struct packed {
      logic                     active;
      logic signed [OFF_W-1:0]  column_offset;
      logic [HGT_W-1:0]         strip_top;
      logic [HGT_W-1:0]         strip_rows;
      logic                     strip_visible;
   } melt_response_type;

   // Tracks the melt state and the responses still owed by the block
   class melt_offset_tracker;
      int                offsets[MAX_COLUMNS];
      logic [31:0]       seed;
      bit                active;
      logic [HGT_W-1:0]  height_reg;
      logic [COUNT_W-1:0] count_reg;
      melt_response_type pending_results[$];
      int                errors;
      int                checked;
      int                mode_hits[4];
      int                melts_finished;
      int                visible_hits;

      function new();
         foreach (offsets[i]) offsets[i] = 0;
         foreach (mode_hits[i]) mode_hits[i] = 0;
         seed           = 32'd1;
         active         = 1'b0;
         height_reg     = 9'd240;
         count_reg      = 8'd80;
         errors         = 0;
         checked        = 0;
         melts_finished = 0;
         visible_hits   = 0;
      endfunction

      function int live_columns();
         if (count_reg == 0) return 1;
         if (count_reg > MAX_COLUMNS) return MAX_COLUMNS;
         return int'(count_reg);
      endfunction

      function int live_height();
         return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
      endfunction

      // Advance the congruential seed and take bits 30..16
      function int draw_random();
         seed = seed * 32'd1103515245 + 32'd12345;
         return int'(seed[30:16]);
      endfunction

      function void write_register(smco_csr_type index, logic [CSR_DATA_W-1:0] value);
         if (index == CSR_HEIGHT) height_reg = value;
         else count_reg = value[COUNT_W-1:0];
      endfunction

      function void note_request(smco_mode_type mode, logic [IDX_W-1:0] column);
         int                n;
         int                h;
         int                y;
         int                off;
         int                top;
         int                rows;
         bit                moving;
         melt_response_type res;
         n = live_columns();
         h = live_height();
         res = '0;
         mode_hits[int'(mode)]++;
         case (mode)
            MODE_START: begin
               // seed the columns with a clamped walk; ignored while running
               if (!active) begin
                  offsets[0] = -(draw_random() % 16);
                  for (int i = 1; i < n; i++) begin
                     y = offsets[i-1] + (draw_random() % 3) - 1;
                     if (y > 0) y = 0;
                     if (y < -15) y = -15;
                     offsets[i] = y;
                  end
                  active = 1'b1;
               end
            end
            MODE_TICK: begin
               if (active) begin
                  moving = 1'b0;
                  for (int i = 0; i < n; i++) begin
                     y = offsets[i];
                     if (y < 0) begin
                        y++;
                        moving = 1'b1;
                     end else if (y < h) begin
                        y += (y < 16) ? y + 1 : 8;
                        if (y > h) y = h;
                        moving = 1'b1;
                     end
                     offsets[i] = y;
                  end
                  if (!moving) begin
                     active = 1'b0;
                     melts_finished++;
                  end
               end
            end
            MODE_QUERY: begin
               // out-of-range columns answer zero apart from the active flag
               if (int'(column) < n) begin
                  off  = offsets[column];
                  top  = (off > 0) ? off : 0;
                  rows = h - top;
                  if (rows < 0) rows = 0;
                  res.column_offset = off[OFF_W-1:0];
                  res.strip_top     = top[HGT_W-1:0];
                  res.strip_rows    = rows[HGT_W-1:0];
                  res.strip_visible = active && (off < h) && (rows > 1);
                  if (res.strip_visible) visible_hits++;
               end
            end
            MODE_STOP: begin
               active = 1'b0;
            end
         endcase
         res.active = active;
         pending_results.push_back(res);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("mismatch at response %0d: %s is %0d, expected %0d", checked, what, got, want);
         errors++;
      endtask

      task check_response(melt_response_type seen);
         melt_response_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("response with nothing outstanding, active", seen.active, 0);
            return;
         end
         want = pending_results.pop_front();
         if (seen.active !== want.active)
            report_mismatch("active", seen.active, want.active);
         if (seen.column_offset !== want.column_offset)
            report_mismatch("column_offset", $signed(seen.column_offset),
                            $signed(want.column_offset));
         if (seen.strip_top !== want.strip_top)
            report_mismatch("strip_top", seen.strip_top, want.strip_top);
         if (seen.strip_rows !== want.strip_rows)
            report_mismatch("strip_rows", seen.strip_rows, want.strip_rows);
         if (seen.strip_visible !== want.strip_visible)
            report_mismatch("strip_visible", seen.strip_visible, want.strip_visible);
         checked++;
      endtask
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [MODE_W-1:0]        req_mode;
   logic [IDX_W-1:0]         req_column_index;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_active;
   logic signed [OFF_W-1:0]  rsp_column_offset;
   logic [HGT_W-1:0]         rsp_strip_top;
   logic [HGT_W-1:0]         rsp_strip_rows;
   logic                     rsp_strip_visible;
   logic                     csr_wr_en;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;

   melt_offset_tracker tracker;
   int                 send_idle_pct;
   int                 recv_idle_pct;
   int                 quiet_cycles;

   screen_melt_column_offsets i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_column_index  (req_column_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_active        (rsp_active),
      .rsp_column_offset (rsp_column_offset),
      .rsp_strip_top     (rsp_strip_top),
      .rsp_strip_rows    (rsp_strip_rows),
      .rsp_strip_visible (rsp_strip_visible),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stall the response channel at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Check each accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_response(melt_response_type'({rsp_active, rsp_column_offset,
            rsp_strip_top, rsp_strip_rows, rsp_strip_visible}));
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("FAIL screen_melt_column_offsets");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one transaction, hold it until accepted, return at a falling edge
   task automatic send_item(smco_mode_type mode, logic [IDX_W-1:0] column);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_column_index <= column;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(mode, column);
      @(negedge clock);
   endtask

   // Drop valid and wait for every response, then a short settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] height, logic [CSR_DATA_W-1:0] count);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_HEIGHT;
      csr_wdata <= height;
      tracker.write_register(CSR_HEIGHT, height);
      @(negedge clock);
      csr_index <= CSR_COUNT;
      csr_wdata <= count;
      tracker.write_register(CSR_COUNT, count);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly whole melts: start, then ticks with queries mixed in; some noise
   task automatic random_items(int total);
      int            n;
      int            pick;
      smco_mode_type mode;
      logic [IDX_W-1:0] column;
      for (int k = 0; k < total; k++) begin
         n    = tracker.live_columns();
         pick = $urandom_range(99);
         if (!tracker.active) begin
            if (pick < 80) mode = MODE_START;
            else if (pick < 88) mode = MODE_TICK;
            else if (pick < 95) mode = MODE_QUERY;
            else mode = MODE_STOP;
         end else begin
            if (pick < 58) mode = MODE_TICK;
            else if (pick < 94) mode = MODE_QUERY;
            else if (pick < 98) mode = MODE_START;
            else mode = MODE_STOP;
         end
         if (mode == MODE_QUERY && $urandom_range(3) != 0)
            column = IDX_W'($urandom_range(n - 1, 0));
         else
            column = IDX_W'($urandom_range(255, 0));
         send_item(mode, column);
      end
   endtask

   task automatic run_phase(int height, int count);
      wait_idle();
      configure(CSR_DATA_W'(height), CSR_DATA_W'(count));
      random_items(PHASE_ITEMS);
   endtask

   initial begin
      tracker          = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_START;
      req_column_index = '0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_HEIGHT;
      csr_wdata        = '0;
      quiet_cycles     = 0;
      send_idle_pct    = 7;
      recv_idle_pct    = 48;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: queries and ticks before any melt, ignored start, stop mid-melt
      send_item(MODE_QUERY, 8'd0);
      send_item(MODE_QUERY, 8'd79);
      send_item(MODE_QUERY, 8'd80);
      send_item(MODE_QUERY, 8'd255);
      send_item(MODE_TICK, 8'd0);
      send_item(MODE_STOP, 8'd0);
      send_item(MODE_START, 8'd0);
      send_item(MODE_START, 8'd255);
      send_item(MODE_QUERY, 8'd0);
      send_item(MODE_QUERY, 8'd79);
      send_item(MODE_QUERY, 8'd80);
      send_item(MODE_TICK, 8'd170);
      send_item(MODE_QUERY, 8'd0);
      send_item(MODE_QUERY, 8'd40);
      send_item(MODE_STOP, 8'd85);
      send_item(MODE_QUERY, 8'd0);
      send_item(MODE_TICK, 8'd0);
      send_item(MODE_START, 8'd0);

      // Sender rarely idles, receiver often stalls
      run_phase(2, 1);
      run_phase(480, 160);
      run_phase(511, 255);

      // Sender often idles, receiver rarely stalls
      send_idle_pct = 48;
      recv_idle_pct = 7;
      run_phase(17, 0);
      run_phase($urandom_range(480, 2), $urandom_range(160, 1));
      run_phase(0, 40);

      // Full throughput
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(100, 160);
      run_phase(300, 7);
      run_phase(1, 20);

      // Drain and look for stray responses
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d transactions: %0d start, %0d tick, %0d query, %0d stop, 9 configurations",
               tracker.checked, tracker.mode_hits[MODE_START], tracker.mode_hits[MODE_TICK],
               tracker.mode_hits[MODE_QUERY], tracker.mode_hits[MODE_STOP]);
      $display("%0d melts finished, %0d visible strips seen, %0d mismatches",
               tracker.melts_finished, tracker.visible_hits, tracker.errors);
      if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
         $display("PASS screen_melt_column_offsets");
      end else begin
         $display("FAIL screen_melt_column_offsets");
      end
      $finish;
   end

endmodule
